FILE: src/x86e_pkg.sv
package x86e_pkg;

  // operand classes
  localparam logic [2:0] KReg = 3'd0;
  localparam logic [2:0] KImm = 3'd1;
  localparam logic [2:0] KMem = 3'd2;
  localparam logic [2:0] KRel = 3'd3;
  localparam logic [2:0] KXmm = 3'd4;
  localparam logic [2:0] KLab = 3'd5;

  // instruction forms
  localparam logic [5:0] FSyscall = 6'd0;
  localparam logic [5:0] FRet     = 6'd1;
  localparam logic [5:0] FPush    = 6'd2;
  localparam logic [5:0] FPop     = 6'd3;
  localparam logic [5:0] FDq      = 6'd4;
  localparam logic [5:0] FXor     = 6'd5;
  localparam logic [5:0] FTest    = 6'd6;
  localparam logic [5:0] FMov     = 6'd7;
  localparam logic [5:0] FAdd     = 6'd8;
  localparam logic [5:0] FSub     = 6'd9;
  localparam logic [5:0] FCmp     = 6'd10;
  localparam logic [5:0] FInc     = 6'd11;
  localparam logic [5:0] FDec     = 6'd12;
  localparam logic [5:0] FDiv     = 6'd13;
  localparam logic [5:0] FLea     = 6'd14;
  localparam logic [5:0] FMovzx   = 6'd15;
  localparam logic [5:0] FMovsd   = 6'd16;
  localparam logic [5:0] FXorpd   = 6'd17;
  localparam logic [5:0] FUcomisd = 6'd18;
  localparam logic [5:0] FCvtt    = 6'd19;
  localparam logic [5:0] FCvtsi   = 6'd20;
  localparam logic [5:0] FAddsd   = 6'd21;
  localparam logic [5:0] FSqrtsd  = 6'd25;
  localparam logic [5:0] FJmp     = 6'd26;
  localparam logic [5:0] FCall    = 6'd27;
  localparam logic [5:0] FJe      = 6'd28;
  localparam logic [5:0] FJbe     = 6'd37;

  localparam int unsigned QueueDepth = 2;

  // one classified instruction: up to eight bytes, a count and a rel32 slot
  typedef struct packed {
    logic [7:0][7:0] bytes;
    logic [3:0]      count;    // 1..8
    logic            err;
    logic            has_rel;
    logic [2:0]      rel_pos;  // first byte of rel32
    logic [3:0]      rel_end;  // length counted from start for rel32 base
    logic [63:0]     target;
  } x86e_item_t;

  function automatic logic [7:0] jcc_op(input logic [5:0] k);
    logic [7:0] r;
    case (k)
      6'd28: r = 8'h84;
      6'd29: r = 8'h85;
      6'd30: r = 8'h8C;
      6'd31: r = 8'h8D;
      6'd32: r = 8'h8E;
      6'd33: r = 8'h8F;
      6'd34: r = 8'h87;
      6'd35: r = 8'h82;
      6'd36: r = 8'h83;
      default: r = 8'h86;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] arith_op(input logic [5:0] k);
    logic [7:0] r;
    case (k)
      6'd21: r = 8'h58;
      6'd22: r = 8'h5C;
      6'd23: r = 8'h59;
      6'd24: r = 8'h5E;
      default: r = 8'h51;
    endcase
    return r;
  endfunction

endpackage

FILE: src/x86e_front.sv
module x86e_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [5:0]            kind_i,
  input  logic [2:0]            first_kind_i,
  input  logic [2:0]            second_kind_i,
  input  logic [2:0]            first_reg_i,
  input  logic [2:0]            second_reg_i,
  input  logic                  byte_register_i,
  input  logic [31:0]           immediate_i,
  input  logic [7:0]            displacement_i,
  input  logic [63:0]           target_address_i,
  input  logic [63:0]           literal_bits_i,
  output logic                  q_valid_o,
  input  logic                  q_ready_i,
  output x86e_pkg::x86e_item_t  q_item_o
);
  import x86e_pkg::*;

  x86e_item_t it;
  logic [7:0][7:0] b;
  logic [3:0] n;
  logic ok;
  logic [2:0] k0, k1, r0, r1;
  logic [7:0] d;

  // small fifo between front and back
  x86e_item_t mem_q [QueueDepth];
  logic [0:0] wp_q, rp_q;
  logic [1:0] cnt_q;

  // append helpers as inline logic via a combinational builder
  always_comb begin
    logic [2:0] base, regf;
    logic nodisp, memf, relf, rrf;
    logic [7:0] opc;
    k0 = first_kind_i; k1 = second_kind_i;
    r0 = first_reg_i;  r1 = second_reg_i;
    d  = displacement_i;
    b  = '0;
    n  = 4'd0;
    ok = 1'b1;
    it = '0;
    base = 3'd0; regf = 3'd0; nodisp = 1'b0; memf = 1'b0; relf = 1'b0; rrf = 1'b0;
    opc = 8'h00;
    it.target = target_address_i;
    unique case (kind_i)
      FSyscall: begin b[0] = 8'h0F; b[1] = 8'h05; n = 4'd2; end
      FRet: begin b[0] = 8'hC3; n = 4'd1; end
      FPush: begin b[0] = 8'h50 + {5'd0, r0}; n = 4'd1; end
      FPop: begin b[0] = 8'h58 + {5'd0, r0}; n = 4'd1; end
      FDq: begin b = literal_bits_i; n = 4'd8; end
      FXor, FTest: begin
        b[0] = 8'h48; b[1] = (kind_i == FXor) ? 8'h33 : 8'h85;
        b[2] = {2'b11, r0, r1}; n = 4'd3;
      end
      FMov: begin
        if (k0 == KReg && k1 == KImm) begin
          if (byte_register_i) begin
            b[0] = 8'hB0 + {5'd0, r0}; b[1] = immediate_i[7:0]; n = 4'd2;
          end else begin
            b[0] = 8'h48; b[1] = 8'hC7; b[2] = {5'b11000, r0};
            b[3] = immediate_i[7:0]; b[4] = immediate_i[15:8];
            b[5] = immediate_i[23:16]; b[6] = immediate_i[31:24]; n = 4'd7;
          end
        end else if (k0 == KReg && k1 == KReg) begin
          b[0] = 8'h48; b[1] = 8'h89; b[2] = {2'b11, r1, r0}; n = 4'd3;
        end else if (k0 == KMem && k1 == KReg) begin
          b[0] = 8'h88; n = 4'd1; memf = 1'b1; regf = r1; base = r0;
          nodisp = (d == 8'd0) && (r0 != 3'd5);
        end else begin
          ok = 1'b0;
        end
      end
      FAdd, FSub, FCmp: begin
        regf = (kind_i == FAdd) ? 3'd0 : (kind_i == FSub) ? 3'd5 : 3'd7;
        if (byte_register_i) begin
          b[0] = 8'h80; b[1] = {2'b11, regf, r0}; b[2] = immediate_i[7:0]; n = 4'd3;
        end else begin
          b[0] = 8'h48; b[1] = 8'h83; b[2] = {2'b11, regf, r0};
          b[3] = immediate_i[7:0]; n = 4'd4;
        end
      end
      FInc, FDec, FDiv: begin
        b[0] = 8'h48; b[1] = (kind_i == FDiv) ? 8'hF7 : 8'hFF;
        regf = (kind_i == FInc) ? 3'd0 : (kind_i == FDec) ? 3'd1 : 3'd6;
        b[2] = {2'b11, regf, r0}; n = 4'd3;
      end
      FLea: begin
        b[0] = 8'h48; b[1] = 8'h8D; n = 4'd2;
        memf = 1'b1; regf = r0; base = r1; nodisp = 1'b0;
      end
      FMovzx: begin
        if (k0 == KReg && (k1 == KReg || k1 == KMem)) begin
          b[0] = 8'h48; b[1] = 8'h0F; b[2] = 8'hB6; n = 4'd3;
          if (k1 == KReg) begin
            b[3] = {2'b11, r0, r1}; n = 4'd4;
          end else begin
            memf = 1'b1; regf = r0; base = r1; nodisp = 1'b0;
          end
        end else begin
          ok = 1'b0;
        end
      end
      FCvtt, FCvtsi: begin
        if ((kind_i == FCvtt && k0 == KReg && k1 == KXmm) ||
            (kind_i == FCvtsi && k0 == KXmm && k1 == KReg)) begin
          b[0] = 8'hF2; b[1] = 8'h48; b[2] = 8'h0F;
          b[3] = (kind_i == FCvtt) ? 8'h2C : 8'h2A;
          b[4] = {2'b11, r0, r1}; n = 4'd5;
        end else begin
          ok = 1'b0;
        end
      end
      FJmp, FCall: begin
        if (k0 == KLab) begin
          b[0] = (kind_i == FJmp) ? 8'hE9 : 8'hE8; n = 4'd5;
          it.has_rel = 1'b1; it.rel_pos = 3'd1; it.rel_end = 4'd5;
        end else begin
          ok = 1'b0;
        end
      end
      default: begin
        if (kind_i >= FJe && kind_i <= FJbe) begin
          if (k0 == KLab) begin
            b[0] = 8'h0F; b[1] = jcc_op(kind_i); n = 4'd6;
            it.has_rel = 1'b1; it.rel_pos = 3'd2; it.rel_end = 4'd6;
          end else begin
            ok = 1'b0;
          end
        end else if (kind_i >= FMovsd && kind_i <= FSqrtsd) begin
          // sse forms: movsd store, or xmm with xmm / rel / mem (no mem for xorpd)
          if (kind_i == FMovsd && k0 == KMem && k1 == KXmm) begin
            b[0] = 8'hF2; b[1] = 8'h0F; b[2] = 8'h11; n = 4'd3;
            memf = 1'b1; regf = r1; base = r0;
            nodisp = (r0 == 3'd4) && (d == 8'd0);
          end else if (k0 == KXmm && (k1 == KXmm || k1 == KRel ||
                       (kind_i != FXorpd && k1 == KMem))) begin
            case (kind_i)
              FMovsd:   begin b[0] = 8'hF2; opc = 8'h10; end
              FXorpd:   begin b[0] = 8'h66; opc = 8'h57; end
              FUcomisd: begin b[0] = 8'h66; opc = 8'h2E; end
              default:  begin b[0] = 8'hF2; opc = arith_op(kind_i); end
            endcase
            b[1] = 8'h0F; b[2] = opc; n = 4'd3;
            if (k1 == KXmm) begin
              b[3] = {2'b11, r0, r1}; n = 4'd4;
            end else if (k1 == KRel) begin
              b[3] = {2'b00, r0, 3'd5}; n = 4'd8;
              it.has_rel = 1'b1; it.rel_pos = 3'd4; it.rel_end = 4'd8;
            end else begin
              memf = 1'b1; regf = r0; base = r1;
              nodisp = (r1 == 3'd4) && (d == 8'd0);
            end
          end else begin
            ok = 1'b0;
          end
        end else begin
          ok = 1'b0;
        end
      end
    endcase
    // memory operand tail: modrm, optional sib, optional disp8
    if (memf) begin
      b[n[2:0]] = {1'b0, ~nodisp, regf, base};
      n = n + 4'd1;
      if (base == 3'd4) begin
        b[n[2:0]] = 8'h24; n = n + 4'd1;
      end
      if (!nodisp) begin
        b[n[2:0]] = d; n = n + 4'd1;
      end
    end
    it.bytes = b;
    it.count = n;
    if (!ok) begin
      it.bytes = '0; it.count = 4'd1; it.err = 1'b1; it.has_rel = 1'b0;
    end
  end

  // queue write and read
  assign ready_o   = (cnt_q != 2'(QueueDepth));
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (valid_i && ready_o) wp_q <= wp_q + 1'b1;
      if (q_valid_o && q_ready_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + 2'(valid_i && ready_o) - 2'(q_valid_o && q_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) mem_q[wp_q] <= it;
  end

endmodule

FILE: src/x86e_back.sv
module x86e_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [63:0]           cfg_data_i,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  x86e_pkg::x86e_item_t  q_item_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  last_o,
  output logic                  error_o
);
  import x86e_pkg::*;

  logic [63:0] addr_q, addr_d;
  logic [31:0] rel_q;
  logic [31:0] rel_w;
  logic [2:0]  idx_q;
  logic        started_q;
  logic [7:0]  byte_c;
  logic        last_c, fire;
  logic [1:0]  off;

  // rel32 computed once when an item reaches the head
  assign rel_w = rel_q;

  always_comb begin
    off = idx_q[1:0] - q_item_i.rel_pos[1:0];
    byte_c = q_item_i.bytes[idx_q];
    if (q_item_i.has_rel && idx_q >= q_item_i.rel_pos) begin
      byte_c = rel_w[8*off +: 8];
    end
  end

  assign last_c = ({1'b0, idx_q} == q_item_i.count - 4'd1);
  // output register accepts when empty or being drained
  assign fire = q_valid_i && started_q && (!valid_o || ready_i);
  assign q_ready_o = fire && last_c;
  assign addr_d = addr_q + {60'd0, q_item_i.count};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0; idx_q <= '0; started_q <= 1'b0; valid_o <= 1'b0;
    end else begin
      valid_o <= fire || (valid_o && !ready_i);
      if (q_valid_i && !started_q) begin
        started_q <= 1'b1;
      end
      if (fire) begin
        if (last_c) begin
          idx_q <= '0; started_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 3'd1;
        end
      end
      if (cfg_we_i) addr_q <= cfg_data_i;
      else if (fire && last_c) addr_q <= addr_d;
    end
  end

  // rel32 setup: registered at the head before the item is started, ahead of the first byte
  always_ff @(posedge clk_i) begin
    if (q_valid_i && !started_q)
      rel_q <= q_item_i.target[31:0] - (addr_q[31:0] + {28'd0, q_item_i.rel_end});
    if (fire) begin
      out_byte_o <= byte_c; last_o <= last_c; error_o <= q_item_i.err;
    end
  end

endmodule

FILE: src/x86_64_instruction_encoder.sv
// Encodes one parsed x86-64 instruction per transfer into its machine code,
// one byte per output transfer with last on the final byte and error (byte
// zero) for an unsupported operand combination. A front stage classifies the
// instruction into up to eight bytes and pushes it into a two-entry queue; the
// back stage emits one byte per cycle while the receiver is ready, after a
// setup step at the queue head in which rel32 is formed from the running
// address. The start address register (address 0x0) sets and reloads that
// address.
module x86_64_instruction_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [5:0]  kind_i,
  input  logic [2:0]  first_kind_i,
  input  logic [2:0]  second_kind_i,
  input  logic [2:0]  first_reg_i,
  input  logic [2:0]  second_reg_i,
  input  logic        byte_register_i,
  input  logic [31:0] immediate_i,
  input  logic [7:0]  displacement_i,
  input  logic [63:0] target_address_i,
  input  logic [63:0] literal_bits_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic        error_o
);
  import x86e_pkg::*;

  logic        q_valid, q_ready, cfg_we;
  x86e_item_t  q_item;
  logic [63:0] start_q;

  // config register
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == 1'b0);
  assign prdata = (paddr == 1'b0) ? start_q : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) start_q <= '0;
    else if (cfg_we) start_q <= pwdata;
  end

  x86e_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .kind_i, .first_kind_i, .second_kind_i,
    .first_reg_i, .second_reg_i, .byte_register_i, .immediate_i, .displacement_i,
    .target_address_i, .literal_bits_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  x86e_back u_back (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_data_i(pwdata),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .valid_o, .ready_i, .out_byte_o, .last_o, .error_o
  );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import x86e_pkg::*;

  // forms that the package leaves unnamed
  localparam logic [5:0] FSubsd = 6'd22;
  localparam logic [5:0] FMulsd = 6'd23;
  localparam logic [5:0] FDivsd = 6'd24;
  localparam logic [5:0] FLastKind = 6'd63;

  localparam int IdleLimit = 6000;
  localparam int DrainCycles = 24;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic [5:0]  kind;
    logic [2:0]  k0;
    logic [2:0]  k1;
    logic [2:0]  r0;
    logic [2:0]  r1;
    logic        breg;
    logic [31:0] imm;
    logic [7:0]  disp;
    logic [63:0] target;
    logic [63:0] lit;
  } insn_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } code_byte_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [0:0] paddr;
  logic [63:0] pwdata, prdata;
  logic valid_i, ready_o, valid_o, ready_i;
  insn_t cur;
  logic [7:0] out_byte_o;
  logic last_o, error_o;

  insn_t pending_insns[$];
  code_byte_t expected_bytes[$];
  logic [7:0] enc_buf[$];
  logic [63:0] pc;
  int mismatches = 0;
  int idle_cycles = 0;
  logic in_taken;
  logic hold_req = 1'b0;

  x86_64_instruction_encoder u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .valid_i, .ready_o,
    .kind_i(cur.kind), .first_kind_i(cur.k0), .second_kind_i(cur.k1),
    .first_reg_i(cur.r0), .second_reg_i(cur.r1), .byte_register_i(cur.breg),
    .immediate_i(cur.imm), .displacement_i(cur.disp),
    .target_address_i(cur.target), .literal_bits_i(cur.lit),
    .valid_o, .ready_i, .out_byte_o, .last_o, .error_o
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // encoding helpers, all appending to enc_buf
  function automatic void put32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) enc_buf.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_rr(input logic [2:0] regf, input logic [2:0] rm);
    enc_buf.push_back({2'b11, regf, rm});
  endfunction

  function automatic void put_mem(input logic [2:0] regf, input logic [2:0] base,
                                  input logic [7:0] d, input bit no_disp);
    enc_buf.push_back({no_disp ? 2'b00 : 2'b01, regf, base});
    if (base == 3'd4) enc_buf.push_back(8'h24);
    if (!no_disp) enc_buf.push_back(d);
  endfunction

  function automatic void put_rip(input logic [2:0] regf, input logic [63:0] tgt,
                                  input logic [63:0] a);
    logic [63:0] diff;
    diff = tgt - (a + 64'd8);
    enc_buf.push_back({2'b00, regf, 3'b101});
    put32(diff[31:0]);
  endfunction

  // xmm,xmm / xmm,rip / xmm,mem after a prefix, 0f and opcode
  function automatic bit sse_form(input logic [7:0] pfx, input logic [7:0] op,
                                  input insn_t it, input logic [63:0] a, input bit mem_ok);
    if (it.k0 != KXmm) return 1'b0;
    if (it.k1 != KXmm && it.k1 != KRel && !(mem_ok && it.k1 == KMem)) return 1'b0;
    enc_buf.push_back(pfx); enc_buf.push_back(8'h0F); enc_buf.push_back(op);
    if (it.k1 == KXmm) put_rr(it.r0, it.r1);
    else if (it.k1 == KRel) put_rip(it.r0, it.target, a);
    else put_mem(it.r0, it.r1, it.disp, it.r1 == 3'd4 && it.disp == 8'd0);
    return 1'b1;
  endfunction

  // works out the bytes of one instruction and advances the running address
  function automatic void encode_insn(input insn_t it);
    bit ok;
    logic [63:0] a, diff;
    logic [2:0] ext;
    logic [7:0] op;
    code_byte_t cb;
    ok = 1'b1;
    a = pc;
    enc_buf.delete();
    case (it.kind)
      FSyscall: begin enc_buf.push_back(8'h0F); enc_buf.push_back(8'h05); end
      FRet: enc_buf.push_back(8'hC3);
      FPush: enc_buf.push_back(8'h50 + it.r0);
      FPop: enc_buf.push_back(8'h58 + it.r0);
      FDq: for (int i = 0; i < 8; i++) enc_buf.push_back(it.lit[8*i +: 8]);
      FXor: begin enc_buf.push_back(8'h48); enc_buf.push_back(8'h33); put_rr(it.r0, it.r1); end
      FTest: begin enc_buf.push_back(8'h48); enc_buf.push_back(8'h85); put_rr(it.r0, it.r1); end
      FMov: begin
        if (it.k0 == KReg && it.k1 == KImm) begin
          if (it.breg) begin
            enc_buf.push_back(8'hB0 + it.r0); enc_buf.push_back(it.imm[7:0]);
          end else begin
            enc_buf.push_back(8'h48); enc_buf.push_back(8'hC7);
            put_rr(3'd0, it.r0); put32(it.imm);
          end
        end else if (it.k0 == KReg && it.k1 == KReg) begin
          enc_buf.push_back(8'h48); enc_buf.push_back(8'h89); put_rr(it.r1, it.r0);
        end else if (it.k0 == KMem && it.k1 == KReg) begin
          enc_buf.push_back(8'h88);
          put_mem(it.r1, it.r0, it.disp, it.disp == 8'd0 && it.r0 != 3'd5);
        end else ok = 1'b0;
      end
      FAdd, FSub, FCmp: begin
        ext = (it.kind == FAdd) ? 3'd0 : (it.kind == FSub) ? 3'd5 : 3'd7;
        if (it.breg) enc_buf.push_back(8'h80);
        else begin enc_buf.push_back(8'h48); enc_buf.push_back(8'h83); end
        put_rr(ext, it.r0);
        enc_buf.push_back(it.imm[7:0]);
      end
      FInc: begin enc_buf.push_back(8'h48); enc_buf.push_back(8'hFF); put_rr(3'd0, it.r0); end
      FDec: begin enc_buf.push_back(8'h48); enc_buf.push_back(8'hFF); put_rr(3'd1, it.r0); end
      FDiv: begin enc_buf.push_back(8'h48); enc_buf.push_back(8'hF7); put_rr(3'd6, it.r0); end
      FLea: begin
        enc_buf.push_back(8'h48); enc_buf.push_back(8'h8D);
        put_mem(it.r0, it.r1, it.disp, 1'b0);
      end
      FMovzx: begin
        if (it.k0 == KReg && (it.k1 == KReg || it.k1 == KMem)) begin
          enc_buf.push_back(8'h48); enc_buf.push_back(8'h0F); enc_buf.push_back(8'hB6);
          if (it.k1 == KReg) put_rr(it.r0, it.r1);
          else put_mem(it.r0, it.r1, it.disp, 1'b0);
        end else ok = 1'b0;
      end
      FMovsd: begin
        if (it.k0 == KMem && it.k1 == KXmm) begin
          enc_buf.push_back(8'hF2); enc_buf.push_back(8'h0F); enc_buf.push_back(8'h11);
          put_mem(it.r1, it.r0, it.disp, it.r0 == 3'd4 && it.disp == 8'd0);
        end else ok = sse_form(8'hF2, 8'h10, it, a, 1'b1);
      end
      FXorpd: ok = sse_form(8'h66, 8'h57, it, a, 1'b0);
      FUcomisd: ok = sse_form(8'h66, 8'h2E, it, a, 1'b1);
      FCvtt, FCvtsi: begin
        if ((it.kind == FCvtt && it.k0 == KReg && it.k1 == KXmm) ||
            (it.kind == FCvtsi && it.k0 == KXmm && it.k1 == KReg)) begin
          enc_buf.push_back(8'hF2); enc_buf.push_back(8'h48); enc_buf.push_back(8'h0F);
          enc_buf.push_back(it.kind == FCvtt ? 8'h2C : 8'h2A);
          put_rr(it.r0, it.r1);
        end else ok = 1'b0;
      end
      FAddsd, FSubsd, FMulsd, FDivsd, FSqrtsd: begin
        case (it.kind)
          FAddsd: op = 8'h58;
          FSubsd: op = 8'h5C;
          FMulsd: op = 8'h59;
          FDivsd: op = 8'h5E;
          default: op = 8'h51;
        endcase
        ok = sse_form(8'hF2, op, it, a, 1'b1);
      end
      FJmp, FCall: begin
        if (it.k0 == KLab) begin
          diff = it.target - (a + 64'd5);
          enc_buf.push_back(it.kind == FJmp ? 8'hE9 : 8'hE8);
          put32(diff[31:0]);
        end else ok = 1'b0;
      end
      default: begin
        if (it.kind >= FJe && it.kind <= FJbe && it.k0 == KLab) begin
          case (it.kind - FJe)
            0: op = 8'h84;
            1: op = 8'h85;
            2: op = 8'h8C;
            3: op = 8'h8D;
            4: op = 8'h8E;
            5: op = 8'h8F;
            6: op = 8'h87;
            7: op = 8'h82;
            8: op = 8'h83;
            default: op = 8'h86;
          endcase
          diff = it.target - (a + 64'd6);
          enc_buf.push_back(8'h0F); enc_buf.push_back(op);
          put32(diff[31:0]);
        end else ok = 1'b0;
      end
    endcase
    if (!ok) begin
      cb = '{data: 8'h00, last: 1'b1, err: 1'b1};
      expected_bytes.push_back(cb);
      pc = a + 64'd1;
    end else begin
      foreach (enc_buf[i]) begin
        cb = '{data: enc_buf[i], last: (i == enc_buf.size() - 1), err: 1'b0};
        expected_bytes.push_back(cb);
      end
      pc = a + 64'(enc_buf.size());
    end
  endfunction

  function automatic insn_t mk(input logic [5:0] kind, input logic [2:0] k0,
                               input logic [2:0] k1, input logic [2:0] r0,
                               input logic [2:0] r1, input logic breg,
                               input logic [31:0] imm, input logic [7:0] disp,
                               input logic [63:0] tgt, input logic [63:0] lit);
    insn_t it;
    it = '{kind, k0, k1, r0, r1, breg, imm, disp, tgt, lit};
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly legal operand classes with random content, some noise
  function automatic insn_t rand_insn();
    insn_t it;
    int pick;
    it.kind = ($urandom_range(0, 15) == 0) ? 6'($urandom_range(38, 63))
                                           : 6'($urandom_range(0, 37));
    it.k0 = 3'($urandom_range(0, 7));
    it.k1 = 3'($urandom_range(0, 7));
    it.r0 = 3'($urandom_range(0, 7));
    it.r1 = 3'($urandom_range(0, 7));
    it.breg = 1'($urandom_range(0, 1));
    it.imm = $urandom();
    it.disp = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    it.target = ($urandom_range(0, 1) == 0) ? rand64() : pc + 64'($urandom_range(0, 4000))
                                                            - 64'd2000;
    it.lit = rand64();
    if ($urandom_range(0, 4) != 0) begin
      pick = $urandom_range(0, 3);
      case (it.kind)
        FMov: begin
          case (pick % 3)
            0: begin it.k0 = KReg; it.k1 = KImm; end
            1: begin it.k0 = KReg; it.k1 = KReg; end
            default: begin it.k0 = KMem; it.k1 = KReg; end
          endcase
        end
        FMovzx: begin it.k0 = KReg; it.k1 = pick[0] ? KReg : KMem; end
        FMovsd, FUcomisd, FAddsd, FSubsd, FMulsd, FDivsd, FSqrtsd: begin
          case (pick)
            0: begin it.k0 = KXmm; it.k1 = KXmm; end
            1: begin it.k0 = KXmm; it.k1 = KRel; end
            2: begin it.k0 = KXmm; it.k1 = KMem; end
            default: begin it.k0 = (it.kind == FMovsd) ? KMem : KXmm; it.k1 = KXmm; end
          endcase
        end
        FXorpd: begin it.k0 = KXmm; it.k1 = pick[0] ? KXmm : KRel; end
        FCvtt: begin it.k0 = KReg; it.k1 = KXmm; end
        FCvtsi: begin it.k0 = KXmm; it.k1 = KReg; end
        default: if (it.kind >= FJmp && it.kind <= FJbe) it.k0 = KLab;
      endcase
    end
    return it;
  endfunction

  // register write over the config port, block idle
  task automatic write_start_addr(input logic [63:0] v);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; paddr = 1'b0; pwdata = v; penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    pc = v;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic drain();
    while (pending_insns.size() != 0 || valid_i || expected_bytes.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // sender: one transfer at a time from the pending queue, random gaps
  int send_gap = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i <= 1'b0;
      cur <= '0;
      send_gap = 0;
    end else if (!valid_i || in_taken) begin
      if (valid_i && in_taken)
        send_gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      if (send_gap > 0) begin
        send_gap--;
        valid_i <= 1'b0;
      end else if (pending_insns.size() != 0) begin
        cur <= pending_insns.pop_front();
        valid_i <= 1'b1;
      end else begin
        valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_i <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      ready_i <= 1'b0;
    end else begin
      if ($urandom_range(0, 5) == 0)
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 50);
      ready_i <= 1'b1;
    end
  end

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  // monitor: predict accepted instructions, check emitted bytes, watchdog
  code_byte_t want;
  always @(posedge clk_i) begin
    in_taken <= valid_i && ready_o;
    if (rst_ni) begin
      if (valid_i && ready_o) encode_insn(cur);
      if (valid_o && ready_i) begin
        if (expected_bytes.size() == 0) begin
          report("unexpected byte", out_byte_o, 8'h00);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte_o !== want.data) report("out_byte", out_byte_o, want.data);
          if (last_o !== want.last) report("last", {7'd0, last_o}, {7'd0, want.last});
          if (error_o !== want.err) report("error", {7'd0, error_o}, {7'd0, want.err});
        end
      end
      if ((valid_i && ready_o) || (valid_o && ready_i) || psel) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout with %0d bytes outstanding", expected_bytes.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = 1'b0; pwdata = '0;
    in_taken = 1'b0;
    pc = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: a range of forms, field extremes and corner encodings
    write_start_addr(64'd0);
    pending_insns.push_back(mk(FSyscall, KReg, KReg, 0, 0, 0, 0, 0, 0, 0));
    pending_insns.push_back(mk(FRet, KReg, KReg, 0, 0, 0, 0, 0, 0, 0));
    pending_insns.push_back(mk(FPush, KReg, KReg, 7, 0, 0, 0, 0, 0, 0));
    pending_insns.push_back(mk(FPop, KReg, KReg, 0, 7, 1, 0, 0, 0, 0));
    pending_insns.push_back(mk(FDq, KImm, KImm, 0, 0, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
    pending_insns.push_back(mk(FXor, KReg, KReg, 7, 7, 0, 0, 0, 0, 0));
    pending_insns.push_back(mk(FMov, KReg, KImm, 3, 0, 0, 32'h8000_0000, 0, 0, 0));
    pending_insns.push_back(mk(FMov, KReg, KImm, 2, 0, 1, 32'h7FFF_FFFF, 0, 0, 0));
    pending_insns.push_back(mk(FMov, KMem, KReg, 5, 1, 0, 0, 8'd0, 0, 0));
    pending_insns.push_back(mk(FMov, KMem, KReg, 4, 2, 0, 0, 8'h80, 0, 0));
    pending_insns.push_back(mk(FMov, KImm, KReg, 0, 0, 0, 0, 0, 0, 0));
    pending_insns.push_back(mk(FCmp, KReg, KImm, 1, 0, 1, 32'hFFFF_FFFF, 0, 0, 0));
    pending_insns.push_back(mk(FLea, KReg, KMem, 6, 4, 0, 0, 8'h7F, 0, 0));
    pending_insns.push_back(mk(FMovzx, KReg, KMem, 2, 4, 0, 0, 8'h01, 0, 0));
    pending_insns.push_back(mk(FMovsd, KMem, KXmm, 4, 3, 0, 0, 8'd0, 0, 0));
    pending_insns.push_back(mk(FMovsd, KXmm, KRel, 1, 0, 0, 0, 0, 64'h0, 0));
    pending_insns.push_back(mk(FXorpd, KXmm, KMem, 1, 1, 0, 0, 0, 0, 0));
    pending_insns.push_back(mk(FSqrtsd, KXmm, KMem, 0, 4, 0, 0, 8'd0, 0, 0));
    pending_insns.push_back(mk(FCvtt, KReg, KXmm, 5, 6, 0, 0, 0, 0, 0));
    pending_insns.push_back(mk(FCvtsi, KXmm, 3'd6, 0, 0, 0, 0, 0, 0, 0));
    pending_insns.push_back(mk(FCall, KLab, KReg, 0, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0));
    pending_insns.push_back(mk(FJbe, KLab, KReg, 0, 0, 0, 0, 0, 64'd0, 0));
    pending_insns.push_back(mk(FJe, 3'd7, KReg, 0, 0, 0, 0, 0, 0, 0));
    pending_insns.push_back(mk(6'd38, KReg, KReg, 0, 0, 0, 0, 0, 0, 0));
    pending_insns.push_back(mk(FLastKind, KLab, KLab, 7, 7, 1, 0, 8'hFF, 0, 0));
    drain();

    // top of the address space, with the receiver holding off for a while
    write_start_addr(64'hFFFF_FFFF_FFFF_FFFF);
    hold_req = 1'b1;
    repeat (150) pending_insns.push_back(rand_insn());
    drain();

    write_start_addr(rand64());
    repeat (160) pending_insns.push_back(rand_insn());
    drain();

    write_start_addr(64'hFFFF_FFFF_FFFF_FFF0);
    repeat (150) pending_insns.push_back(rand_insn());
    drain();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
